// ===== design/rounding_signed_divider_core_defines.svh =====
// Assertion macros shared by the rounding divider RTL
`ifndef ROUNDING_SIGNED_DIVIDER_CORE_DEFINES_SVH
`define ROUNDING_SIGNED_DIVIDER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, idle during reset
`define RSD_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rounding divider check failed");

// next-cycle implication
`define RSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rounding divider check failed");

`endif

// ===== design/rsd_pkg.sv =====
// Word types for the rounding signed divider
package rsd_pkg;

	localparam int WordWidth = 64;

	typedef struct packed {
		logic signed [WordWidth-1:0] numerator;
		logic signed [WordWidth-1:0] denominator;
	} operand_t;

	typedef struct packed {
		logic signed [WordWidth-1:0] quotient;
		logic                        bad_divisor;
	} result_t;

endpackage

// ===== design/rounding_signed_divider_core.sv =====
// Rounding signed divider: pipelined restoring division, ties away from zero.
// Takes one operand word per cycle (busy stays low) and gives its result word,
// marked by done for a single cycle. The restoring divider gives one quotient
// bit per stage, each with one DATA_WIDTH-bit compare and subtract, behind a
// magnitude stage and a rounding-add stage, and followed by a sign-restore
// stage. Operands use their low DATA_WIDTH bits; the quotient is sign-extended
// to 64 bits. A zero or negative denominator gives a quotient of zero with
// bad_divisor set. Results cannot be held off.
`include "rounding_signed_divider_core_defines.svh"

module rounding_signed_divider_core #(
	parameter int DATA_WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rsd_pkg::operand_t operand,
	output logic             done,
	output rsd_pkg::result_t  result
);
	import rsd_pkg::*;

	localparam int DW = DATA_WIDTH;

	logic [DW-1:0] num_w;
	logic [DW-1:0] den_w;

	// stage 1: magnitude and divisor check
	logic          v_s1;
	logic          neg_s1;
	logic          bad_s1;
	logic [DW-1:0] mag_s1;
	logic [DW-2:0] den_s1;

	// division stages; index 0 is the rounding-add stage
	logic          v_sd   [0:DW];
	logic          neg_sd [0:DW];
	logic          bad_sd [0:DW];
	logic [DW-2:0] den_sd [0:DW];
	logic [DW-2:0] rem_sd [0:DW];
	logic [DW-1:0] dvd_sd [0:DW];

	logic [DW-1:0] q_w;
	logic [DW-1:0] r_w;

	assign busy  = 1'b0;
	assign num_w = operand.numerator[DW-1:0];
	assign den_w = operand.denominator[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= num_w[DW-1];
		bad_s1 <= (den_w == '0) || den_w[DW-1];
		mag_s1 <= num_w[DW-1] ? (~num_w + 1'b1) : num_w;
		den_s1 <= den_w[DW-2:0];
	end

	// magnitude plus half the divisor stays below 2^DW
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else begin
			v_sd[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_sd[0] <= neg_s1;
		bad_sd[0] <= bad_s1;
		den_sd[0] <= den_s1;
		rem_sd[0] <= '0;
		dvd_sd[0] <= mag_s1 + {2'b00, den_s1[DW-2:1]};
	end

	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [DW-1:0] trial;
		logic [DW-1:0] diff;
		logic          ge;

		always_comb begin
			trial = {rem_sd[k], dvd_sd[k][DW-1]};
			diff  = trial - {1'b0, den_sd[k]};
			ge    = trial >= {1'b0, den_sd[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		// remainder stays below the divisor, so DW-1 bits hold it
		always_ff @(posedge clk) begin
			neg_sd[k+1] <= neg_sd[k];
			bad_sd[k+1] <= bad_sd[k];
			den_sd[k+1] <= den_sd[k];
			rem_sd[k+1] <= ge ? diff[DW-2:0] : trial[DW-2:0];
			dvd_sd[k+1] <= {dvd_sd[k][DW-2:0], ge};
		end
	end

	assign q_w = dvd_sd[DW];
	assign r_w = neg_sd[DW] ? (~q_w + 1'b1) : q_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_sd[DW];
		end
	end

	always_ff @(posedge clk) begin
		result.quotient    <= bad_sd[DW] ? '0 : WordWidth'(signed'(r_w));
		result.bad_divisor <= bad_sd[DW];
	end

	`RSD_ASSERT_IMPLIES(a_bad_gives_zero, done && result.bad_divisor, result.quotient == '0)
	`RSD_ASSERT_NEXT(a_last_stage_to_out, v_sd[DW], done)
	`RSD_ASSERT_IMPLIES(a_rem_below_den, v_sd[DW] && !bad_sd[DW], rem_sd[DW] < den_sd[DW])

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the rounding signed divider core
module tb;
	import rsd_pkg::*;

	localparam int DataWidth = 64;
	localparam int Latency   = DataWidth + 3;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	operand_t operand;
	logic     done;
	result_t  result;

	result_t  pending_results[$];
	int       errors = 0;

	rounding_signed_divider_core #(
		.DATA_WIDTH(DataWidth)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.operand(operand),
		.done   (done),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Round half away from zero: |n| + floor(d/2), divide, put the sign back
	function automatic result_t rounded_quotient(operand_t op);
		result_t     r;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] mag;
		logic [64:0] sum;
		logic [64:0] q;
		r.quotient    = '0;
		r.bad_divisor = 1'b0;
		n = op.numerator;
		d = op.denominator;
		if (d == 64'd0 || d[63]) begin
			r.bad_divisor = 1'b1;
			return r;
		end
		mag = n[63] ? (~n + 64'd1) : n;
		sum = {1'b0, mag} + {2'b00, d[63:1]};
		q   = sum / {1'b0, d};
		r.quotient = n[63] ? (~q[63:0] + 64'd1) : q[63:0];
		return r;
	endfunction

	function automatic logic [63:0] random_u64();
		return {$urandom, $urandom};
	endfunction

	function automatic operand_t random_operand();
		operand_t    op;
		logic [63:0] d;
		logic [63:0] n;
		logic [63:0] q;
		d = (random_u64() >> 1) >> $urandom_range(0, 62);
		if (d == 64'd0)
			d = 64'd1;
		case ($urandom_range(0, 9))
			0: d = random_u64() | 64'h8000_0000_0000_0000;
			1: d = ($urandom_range(0, 1) != 0) ? 64'd0 : 64'h8000_0000_0000_0000;
			2: d = 64'($urandom_range(1, 16));
			default: ;
		endcase
		case ($urandom_range(0, 5))
			// around an exact half: k*d + d/2 + {-1, 0, +1}
			0, 1: begin
				q = 64'($urandom_range(0, 1000));
				n = q * d + (d >> 1) + 64'($signed($urandom_range(0, 2)) - 1);
				if ($urandom_range(0, 1) != 0)
					n = ~n + 64'd1;
			end
			2: begin
				case ($urandom_range(0, 4))
					0: n = 64'h8000_0000_0000_0000;
					1: n = 64'h7fff_ffff_ffff_ffff;
					2: n = 64'd0;
					3: n = 64'd1;
					default: n = '1;
				endcase
			end
			3: n = 64'($signed($urandom_range(0, 200)) - 100);
			default: n = random_u64();
		endcase
		op.numerator   = n;
		op.denominator = d;
		return op;
	endfunction

	// called just after a rising edge; start stays high on return
	task automatic send_word(operand_t op);
		logic was_busy;
		start   <= 1'b1;
		operand <= op;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		pending_results.push_back(rounded_quotient(op));
	endtask

	task automatic idle_gap(int pct);
		while ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic send_pair(logic [63:0] n, logic [63:0] d);
		operand_t op;
		op.numerator   = n;
		op.denominator = d;
		send_word(op);
	endtask

	task automatic test_directed();
		localparam logic [63:0] Min = 64'h8000_0000_0000_0000;
		localparam logic [63:0] Max = 64'h7fff_ffff_ffff_ffff;
		// most negative numerator and the full-scale extremes
		send_pair(Min, 64'd1);
		send_pair(Min, 64'd2);
		send_pair(Min, Max);
		send_pair(Max, 64'd1);
		send_pair(Max, 64'd2);
		send_pair(Max, Max);
		send_pair(64'd0, 64'd1);
		send_pair('1, 64'd1);
		send_pair('1, Max);
		// ties go away from zero, just below a tie goes down
		send_pair(64'd7, 64'd2);
		send_pair(-64'sd7, 64'd2);
		send_pair(64'd6, 64'd4);
		send_pair(-64'sd6, 64'd4);
		send_pair(64'd5, 64'd4);
		send_pair(-64'sd5, 64'd4);
		send_pair(64'd1, 64'd3);
		send_pair(64'd2, 64'd3);
		send_pair(-64'sd2, 64'd3);
		// bad divisors: zero, minus one, most negative
		send_pair(64'd123, 64'd0);
		send_pair(64'd0, 64'd0);
		send_pair(Max, '1);
		send_pair(Min, Min);
		send_pair(random_u64(), random_u64() | Min);
		send_pair('1, 64'hffff_ffff_ffff_fffe);
	endtask

	task automatic test_random(int idle_pct, int count);
		repeat (count) begin
			idle_gap(idle_pct);
			send_word(random_operand());
		end
	endtask

	// back-to-back burst, hold off until the pipe is empty, then a second burst
	task automatic test_pause_until_empty();
		repeat (20)
			send_word(random_operand());
		wait_drained();
		repeat (5)
			send_word(random_operand());
	endtask

	always @(negedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word q=%0d bad=%0b", $time,
					result.quotient, result.bad_divisor);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result.quotient !== want.quotient) begin
					$display("%0t: quotient expected %0d actual %0d", $time,
						want.quotient, result.quotient);
					errors++;
				end
				if (result.bad_divisor !== want.bad_divisor) begin
					$display("%0t: bad_divisor expected %0b actual %0b", $time,
						want.bad_divisor, result.bad_divisor);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n  <= 1'b0;
		start   <= 1'b0;
		operand <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pause_until_empty();
		test_random(15, 575);
		test_random(82, 575);
		test_random(0, 575);

		wait_drained();
		repeat (Latency + 8) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/rsd_pkg.sv
design/rounding_signed_divider_core.sv
dv/tb.sv
